### rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, quiet while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Implication written out: antecedent then consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

### rtl/ffpa_pkg.sv
`timescale 1ns / 1ps

package ffpa_pkg;

	localparam int POOL_SIZE    = 128;
	localparam int MAX_SEGMENTS = 128;

	localparam int SEG_W  = $clog2(MAX_SEGMENTS);
	localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
	localparam int ADDR_W = $clog2(POOL_SIZE);
	localparam int LEN_W  = $clog2(POOL_SIZE + 1);

	localparam int OWNER_W    = 8;
	localparam int REQ_W      = 8;
	localparam int STATUS_W   = 2;
	localparam int OUT_ADDR_W = 7;
	localparam int OUT_LEN_W  = 8;
	localparam int CMP_W      = (LEN_W > REQ_W) ? LEN_W : REQ_W;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_FIT   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_OWNER = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_BAD      = 2'd3;

	typedef struct packed {
		logic [ADDR_W-1:0]  start;
		logic [LEN_W-1:0]   len;
		logic [OWNER_W-1:0] owner;
		logic               used;
	} seg_t;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [OUT_ADDR_W-1:0] start_address;
		logic [OUT_LEN_W-1:0]  part_length;
	} result_t;

	typedef enum logic [2:0] {
		FS_INIT,
		FS_IDLE,
		FS_SCAN,
		FS_FNXT,
		FS_SHIFT,
		FS_FIX,
		FS_DONE
	} fsm_t;

endpackage

### rtl/ffpa_if.sv
`timescale 1ns / 1ps

interface ffpa_cmd_if;
	import ffpa_pkg::*;

	logic               valid;
	logic               ready;
	logic               action;
	logic [OWNER_W-1:0] owner_id;
	logic [REQ_W-1:0]   request_length;

	modport source (output valid, output action, output owner_id, output request_length,
		input ready);
	modport sink (input valid, input action, input owner_id, input request_length,
		output ready);
endinterface

interface ffpa_res_if;
	import ffpa_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [OUT_ADDR_W-1:0] start_address;
	logic [OUT_LEN_W-1:0]  part_length;

	modport source (output valid, output status, output start_address, output part_length,
		input ready);
	modport sink (input valid, input status, input start_address, input part_length,
		output ready);
endinterface

### rtl/ffpa_out_reg.sv
`timescale 1ns / 1ps

module ffpa_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  ffpa_pkg::result_t data,
	output logic             can_load,
	ffpa_res_if.source       res
);
	import ffpa_pkg::*;

	logic    valid_q;
	result_t data_q;

	// free slot, or the held word leaves this edge
	assign can_load = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data;
		end
	end

	assign res.valid         = valid_q;
	assign res.status        = data_q.status;
	assign res.start_address = data_q.start_address;
	assign res.part_length   = data_q.part_length;

endmodule

### rtl/first_fit_partition_allocator.sv
`timescale 1ns / 1ps
// First-fit partition allocator over a pool of POOL_SIZE units.
// cmd channel: one word per request (action, owner_id, request_length).
//   action 0 allocates request_length units for owner_id, action 1 frees
//   the lowest-address partition held by owner_id, merging free neighbours.
// res channel: exactly one word per request (status, start_address,
//   part_length), in request order.
// Flow: a request is taken only in idle; it scans the partition table
//   at one entry per cycle, then shifts entries one per cycle for a split
//   or merge before its result word is loaded. The partition memory has
//   one read port and one write port, so a shift reads each entry and
//   writes it to its new place.
// Bad requests (owner 0, or zero length on an allocation) skip the scan and go to DONE.
// Reset: the table comes up holding one free partition covering the pool;
//   the INIT state writes that entry, so cmd.ready rises only once the
//   block has moved on to idle.
// Stall: the result waits in an output register; a new request is still
//   taken meanwhile, and its result waits in DONE until the register frees.

module first_fit_partition_allocator (
	input  logic       clk,
	input  logic       arst_n,
	ffpa_cmd_if.sink   cmd,
	ffpa_res_if.source res
);
	import ffpa_pkg::*;

	// partition table, one word per entry, registered read
	seg_t mem [MAX_SEGMENTS];
	seg_t mem_rdata;
	logic [SEG_W-1:0] mem_raddr;
	logic [SEG_W-1:0] mem_waddr;
	logic             mem_we;
	seg_t             mem_wdata;

	fsm_t state_q, state_d;

	logic [CNT_W-1:0]   cnt_q;
	logic               act_q;
	logic [OWNER_W-1:0] own_q;
	logic [REQ_W-1:0]   req_q;

	// scan pipeline: read issued, data checked in the next cycle
	logic [CNT_W-1:0] rd_idx_q;
	logic             chk_vld_s1;
	logic [CNT_W-1:0] chk_idx_s1;
	seg_t             prev_q;
	seg_t             hit_q;
	logic [CNT_W-1:0] hit_idx_q;

	// shift engine
	logic             sh_up_q;
	logic [CNT_W-1:0] sh_sp_q;
	logic [CNT_W-1:0] sh_n_q;
	logic [CNT_W-1:0] sh_off_q;
	logic             wr_pend_s1;
	logic [SEG_W-1:0] wr_addr_s1;

	result_t res_q;
	logic    out_load;
	logic    out_can_load;

	logic cmd_acc;
	logic cmd_bad;

	// scan decode
	logic [CMP_W-1:0] len_ext, req_ext;
	logic alloc_exact, alloc_split, free_hit, scan_hit, scan_end;

	// merge decode for a free
	logic             nxt_ok, prv_ok;
	logic [CNT_W-1:0] fr_src, fr_off;
	logic [SEG_W-1:0] fr_waddr;
	seg_t             fr_wdata;

	assign cmd_acc = cmd.valid && cmd.ready;
	assign cmd_bad = (cmd.owner_id == '0) ||
		((cmd.action == ACT_ALLOC) && (cmd.request_length == '0));

	assign len_ext = CMP_W'(mem_rdata.len);
	assign req_ext = CMP_W'(req_q);

	always_comb begin
		alloc_exact = chk_vld_s1 && !mem_rdata.used && (len_ext == req_ext);
		alloc_split = chk_vld_s1 && !mem_rdata.used && (len_ext > req_ext) &&
			(cnt_q < CNT_W'(MAX_SEGMENTS));
		free_hit    = chk_vld_s1 && mem_rdata.used && (mem_rdata.owner == own_q);
		scan_hit    = (state_q == FS_SCAN) &&
			((act_q == ACT_ALLOC) ? (alloc_exact || alloc_split) : free_hit);
		scan_end    = (state_q == FS_SCAN) && !chk_vld_s1 && (rd_idx_q >= cnt_q);
	end

	// free: next entry arrives on the read port, previous one was kept
	always_comb begin
		nxt_ok = ((hit_idx_q + CNT_W'(1)) < cnt_q) && !mem_rdata.used;
		prv_ok = (hit_idx_q != '0) && !prev_q.used;
		fr_wdata = '0;
		if (nxt_ok && prv_ok) begin
			fr_waddr       = SEG_W'(hit_idx_q - CNT_W'(1));
			fr_wdata.start = prev_q.start;
			fr_wdata.len   = prev_q.len + hit_q.len + mem_rdata.len;
			fr_src         = hit_idx_q + CNT_W'(2);
			fr_off         = CNT_W'(2);
		end else if (nxt_ok) begin
			fr_waddr       = SEG_W'(hit_idx_q);
			fr_wdata.start = hit_q.start;
			fr_wdata.len   = hit_q.len + mem_rdata.len;
			fr_src         = hit_idx_q + CNT_W'(2);
			fr_off         = CNT_W'(1);
		end else if (prv_ok) begin
			fr_waddr       = SEG_W'(hit_idx_q - CNT_W'(1));
			fr_wdata.start = prev_q.start;
			fr_wdata.len   = prev_q.len + hit_q.len;
			fr_src         = hit_idx_q + CNT_W'(1);
			fr_off         = CNT_W'(1);
		end else begin
			fr_waddr       = SEG_W'(hit_idx_q);
			fr_wdata.start = hit_q.start;
			fr_wdata.len   = hit_q.len;
			fr_src         = cnt_q;
			fr_off         = '0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FS_INIT: begin
				state_d = FS_IDLE;
			end
			FS_IDLE: begin
				if (cmd_acc) begin
					state_d = cmd_bad ? FS_DONE : FS_SCAN;
				end
			end
			FS_SCAN: begin
				if (scan_hit) begin
					if (act_q == ACT_FREE) begin
						state_d = FS_FNXT;
					end else if (alloc_exact) begin
						state_d = FS_DONE;
					end else begin
						state_d = FS_SHIFT;
					end
				end else if (scan_end) begin
					state_d = FS_DONE;
				end
			end
			FS_FNXT: begin
				state_d = FS_SHIFT;
			end
			FS_SHIFT: begin
				if ((sh_n_q == '0) && !wr_pend_s1) begin
					state_d = (act_q == ACT_ALLOC) ? FS_FIX : FS_DONE;
				end
			end
			FS_FIX: begin
				state_d = FS_DONE;
			end
			FS_DONE: begin
				if (out_can_load) begin
					state_d = FS_IDLE;
				end
			end
			default: begin
				state_d = FS_INIT;
			end
		endcase
	end

	// memory port and handshake controls
	always_comb begin
		cmd.ready = (state_q == FS_IDLE);
		out_load  = (state_q == FS_DONE) && out_can_load;
		mem_raddr = rd_idx_q[SEG_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		case (state_q)
			FS_INIT: begin
				mem_we        = 1'b1;
				mem_wdata.len = LEN_W'(POOL_SIZE);
			end
			FS_SCAN: begin
				if (scan_hit && (act_q == ACT_ALLOC)) begin
					// used part takes the low end of the partition
					mem_we          = 1'b1;
					mem_waddr       = chk_idx_s1[SEG_W-1:0];
					mem_wdata.start = mem_rdata.start;
					mem_wdata.len   = LEN_W'(req_q);
					mem_wdata.owner = own_q;
					mem_wdata.used  = 1'b1;
				end
			end
			FS_FNXT: begin
				mem_we    = 1'b1;
				mem_waddr = fr_waddr;
				mem_wdata = fr_wdata;
			end
			FS_SHIFT: begin
				mem_raddr = sh_sp_q[SEG_W-1:0];
				mem_we    = wr_pend_s1;
				mem_waddr = wr_addr_s1;
				mem_wdata = mem_rdata;
			end
			FS_FIX: begin
				// free remainder above the new partition
				mem_we          = 1'b1;
				mem_waddr       = SEG_W'(hit_idx_q + CNT_W'(1));
				mem_wdata.start = hit_q.start + ADDR_W'(req_q);
				mem_wdata.len   = hit_q.len - LEN_W'(req_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FS_INIT;
			cnt_q      <= CNT_W'(1);
			rd_idx_q   <= '0;
			chk_vld_s1 <= 1'b0;
			sh_n_q     <= '0;
			wr_pend_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			chk_vld_s1 <= (state_q == FS_SCAN) && !scan_hit && (rd_idx_q < cnt_q);
			wr_pend_s1 <= (state_q == FS_SHIFT) && (sh_n_q != '0);
			case (state_q)
				FS_IDLE: begin
					rd_idx_q <= '0;
				end
				FS_SCAN: begin
					if (rd_idx_q < cnt_q) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (scan_hit && (act_q == ACT_ALLOC) && !alloc_exact) begin
						cnt_q  <= cnt_q + CNT_W'(1);
						sh_n_q <= cnt_q - CNT_W'(1) - chk_idx_s1;
					end
				end
				FS_FNXT: begin
					cnt_q  <= cnt_q - fr_off;
					sh_n_q <= cnt_q - fr_src;
				end
				FS_SHIFT: begin
					if (sh_n_q != '0) begin
						sh_n_q <= sh_n_q - CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		chk_idx_s1 <= rd_idx_q;
		case (state_q)
			FS_IDLE: begin
				if (cmd_acc) begin
					act_q <= cmd.action;
					own_q <= cmd.owner_id;
					req_q <= cmd.request_length;
					res_q <= '{status: STATUS_BAD, start_address: '0, part_length: '0};
				end
			end
			FS_SCAN: begin
				if (chk_vld_s1 && !scan_hit) begin
					prev_q <= mem_rdata;
				end
				if (scan_hit) begin
					hit_q     <= mem_rdata;
					hit_idx_q <= chk_idx_s1;
					res_q.status        <= STATUS_DONE;
					res_q.start_address <= OUT_ADDR_W'(mem_rdata.start);
					res_q.part_length   <= (act_q == ACT_ALLOC) ?
						OUT_LEN_W'(req_q) : OUT_LEN_W'(mem_rdata.len);
					// split: move entries above the hit up by one, top first
					sh_up_q  <= 1'b1;
					sh_sp_q  <= cnt_q - CNT_W'(1);
					sh_off_q <= CNT_W'(1);
				end else if (scan_end) begin
					res_q.status <= (act_q == ACT_ALLOC) ? STATUS_NO_FIT : STATUS_NO_OWNER;
				end
			end
			FS_FNXT: begin
				// merge: close the gap, bottom first
				sh_up_q  <= 1'b0;
				sh_sp_q  <= fr_src;
				sh_off_q <= fr_off;
			end
			FS_SHIFT: begin
				if (sh_n_q != '0) begin
					sh_sp_q    <= sh_up_q ? (sh_sp_q - CNT_W'(1)) : (sh_sp_q + CNT_W'(1));
					wr_addr_s1 <= sh_up_q ? SEG_W'(sh_sp_q + sh_off_q) :
						SEG_W'(sh_sp_q - sh_off_q);
				end
			end
			default: begin
			end
		endcase
	end

	ffpa_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (out_load),
		.data     (res_q),
		.can_load (out_can_load),
		.res      (res)
	);

`include "assert_macros.svh"

	`ASSERT_CLK(a_cnt_range, (cnt_q != '0) && (cnt_q <= CNT_W'(MAX_SEGMENTS)), "entry count out of range")
	`ASSERT_IMPL(a_shift_no_clash, (state_q == FS_SHIFT) && mem_we, mem_waddr != mem_raddr, "shift write hits read address")
	`ASSERT_NEXT(a_accept_moves, cmd_acc, (state_q == FS_SCAN) || (state_q == FS_DONE), "request accepted but not started")
	`ASSERT_IMPL(a_load_free, out_load, !res.valid || res.ready, "result overwrites a waiting word")

endmodule
